[design/ole_pkg.sv]
// Shared types and codes for the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;

  // Wide enough for any index or count up to the largest supported depth.
  localparam int CTL_W = 7;

  // Request codes
  localparam logic [2:0] REQ_INS_FRONT = 3'd0;
  localparam logic [2:0] REQ_INS_BACK  = 3'd1;
  localparam logic [2:0] REQ_INS_IDX   = 3'd2;
  localparam logic [2:0] REQ_DEL_FRONT = 3'd3;
  localparam logic [2:0] REQ_DEL_BACK  = 3'd4;
  localparam logic [2:0] REQ_DEL_POS   = 3'd5;
  localparam logic [2:0] REQ_SEARCH    = 3'd6;
  localparam logic [2:0] REQ_DUMP      = 3'd7;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  // Cell operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;
  localparam logic [1:0] OP_ROT  = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [CTL_W-1:0] idx;
    logic [CTL_W-1:0] cnt;
  } cell_ctl_t;

endpackage
`default_nettype wire

[design/ole_cell.sv]
// One storage cell of the list chain: hold, load, or take a neighbor's or the front cell's entry.
`timescale 1ns / 1ps
`default_nettype none
module ole_cell #(
  parameter int IDX = 0
) (
  input  wire                  clk,
  input  ole_pkg::cell_ctl_t   ctl,
  input  wire signed [31:0]    value,
  input  wire signed [31:0]    left,
  input  wire signed [31:0]    right,
  input  wire signed [31:0]    head,
  output logic signed [31:0]   data
);
  import ole_pkg::*;

  localparam logic [CTL_W-1:0] MY     = CTL_W'(IDX);
  localparam logic [CTL_W-1:0] MY_INC = CTL_W'(IDX + 1);

  logic signed [31:0] data_next;

  always_comb begin
    data_next = data;
    case (ctl.op)
      OP_INS: begin
        if (MY == ctl.idx) begin
          data_next = value;
        end else if (MY > ctl.idx && MY <= ctl.cnt) begin
          data_next = left;
        end
      end
      OP_DEL: begin
        if (MY >= ctl.idx) begin
          data_next = right;
        end
      end
      OP_ROT: begin
        // the last valid entry wraps around to take the front
        if (MY_INC == ctl.cnt) begin
          data_next = head;
        end else if (MY_INC < ctl.cnt) begin
          data_next = right;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule
`default_nettype wire

[design/ordered_list_engine_top.sv]
// Top level of the ordered list engine: control, entry count and cell chain.
`timescale 1ns / 1ps
`default_nettype none
// Bounded ordered list of signed 32-bit values held in a chain of DEPTH cells.
// Inserts and deletes shift the cells behind the affected place in the
// accepting cycle and give one result. Search and dump rotate the valid
// entries through the front cell, one entry per cycle while the output
// register is free, and take one rotation step per entry (none on an empty
// list). A dump emits one result per rotation step and pauses while its
// output register is not taken. A new request is taken once the previous
// one has finished and the output register is free or being read out.
module ordered_list_engine_top #(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [2:0]         req_type,
  input  wire  signed [31:0] value,
  input  wire  [4:0]         position,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [2:0]         status,
  output logic [4:0]         found_position,
  output logic signed [31:0] element,
  output logic [4:0]         entry_count,
  output logic               last
);
  import ole_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CTL_W-1:0] DEPTH_C = CTL_W'(DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DUMP   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [CW-1:0]      rc, rc_next;
  logic               found, found_next;
  logic [CW-1:0]      fpos, fpos_next;
  logic signed [31:0] key, key_next;

  logic               out_load;
  logic [2:0]         o_status;
  logic [4:0]         o_fpos;
  logic signed [31:0] o_elem;
  logic               o_last;

  cell_ctl_t          ctl;
  logic signed [31:0] cells [DEPTH];

  logic               accept, out_free, step, rot_last, hit;
  logic [CTL_W-1:0]   cx, px, ins_idx;
  logic [CW-1:0]      rc_inc;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign step     = (state != S_IDLE) && out_free;
  assign cx       = CTL_W'(count);
  assign px       = CTL_W'(position);
  assign rc_inc   = rc + 1'b1;
  assign rot_last = (rc_inc == count);
  assign hit      = (cells[0] == key);

  always_comb begin
    case (req_type)
      REQ_INS_FRONT: ins_idx = '0;
      REQ_INS_BACK:  ins_idx = cx;
      default:       ins_idx = px;
    endcase
  end

  always_comb begin
    state_next = state;
    count_next = count;
    rc_next    = rc;
    found_next = found;
    fpos_next  = fpos;
    key_next   = key;
    ctl.op     = OP_HOLD;
    ctl.idx    = '0;
    ctl.cnt    = cx;
    out_load   = 1'b0;
    o_status   = ST_OK;
    o_fpos     = '0;
    o_elem     = '0;
    o_last     = 1'b1;

    if (accept) begin
      out_load = 1'b1;
      case (req_type)
        REQ_INS_FRONT, REQ_INS_BACK, REQ_INS_IDX: begin
          if (cx == DEPTH_C) begin
            o_status = ST_FULL;
          end else if (ins_idx > cx) begin
            o_status = ST_RANGE;
          end else begin
            ctl.op     = OP_INS;
            ctl.idx    = ins_idx;
            count_next = count + 1'b1;
          end
        end
        REQ_DEL_FRONT, REQ_DEL_BACK, REQ_DEL_POS: begin
          if (count == '0) begin
            o_status = ST_EMPTY;
          end else if (req_type == REQ_DEL_POS && (px == '0 || px > cx)) begin
            o_status = ST_RANGE;
          end else begin
            ctl.op = OP_DEL;
            if (req_type == REQ_DEL_FRONT) begin
              ctl.idx = '0;
            end else if (req_type == REQ_DEL_BACK) begin
              ctl.idx = cx - 1'b1;
            end else begin
              ctl.idx = px - 1'b1;
            end
            count_next = count - 1'b1;
          end
        end
        REQ_SEARCH: begin
          if (count == '0) begin
            o_status = ST_NOTFOUND;
          end else begin
            out_load   = 1'b0;
            state_next = S_SEARCH;
            key_next   = value;
            found_next = 1'b0;
            fpos_next  = '0;
            rc_next    = '0;
          end
        end
        default: begin
          if (count == '0) begin
            o_status = ST_EMPTY;
          end else begin
            out_load   = 1'b0;
            state_next = S_DUMP;
            rc_next    = '0;
          end
        end
      endcase
    end else if (step) begin
      // rotate one entry through the front cell
      ctl.op  = OP_ROT;
      rc_next = rc_inc;
      if (state == S_DUMP) begin
        out_load = 1'b1;
        o_elem   = cells[0];
        o_last   = rot_last;
      end else begin
        if (hit && !found) begin
          found_next = 1'b1;
          fpos_next  = rc_inc;
        end
        if (rot_last) begin
          out_load = 1'b1;
          if (found) begin
            o_fpos = 5'(fpos);
          end else if (hit) begin
            o_fpos = 5'(rc_inc);
          end else begin
            o_status = ST_NOTFOUND;
          end
        end
      end
      if (rot_last) begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rc        <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      rc    <= rc_next;
      found <= found_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fpos <= fpos_next;
    key  <= key_next;
    if (out_load) begin
      status         <= o_status;
      found_position <= o_fpos;
      element        <= o_elem;
      entry_count    <= 5'(count_next);
      last           <= o_last;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = value;
    end else begin : g_mid
      assign left_d = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign right_d = cells[i];
    end else begin : g_inner
      assign right_d = cells[i+1];
    end
    ole_cell #(
      .IDX(i)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .value(value),
      .left (left_d),
      .right(right_d),
      .head (cells[0]),
      .data (cells[i])
    );
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CTL_W'(count) <= DEPTH_C)
    else $error("entry count above depth");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("request taken while a rotation runs");

  a_rot_nonempty: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> (count != '0 && rc < count))
    else $error("rotation step outside the valid entries");

  a_count_frozen: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |=> $stable(count))
    else $error("entry count changed during a rotation");

endmodule
`default_nettype wire
